// File: rtl/ssp_pkg.sv
// shared types and constants for the single-source shortest path block
// no dependencies

package ssp_pkg;

    // default sizes, handed to the top level parameters
    localparam int NODES_DEF = 16;
    localparam int EDGES_DEF = 64;

    // fixed field widths
    localparam int NODE_FIELD_W = 4;
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 24;
    localparam int COUNT_W      = 5;
    localparam int OP_W         = 2;

    localparam int EDGE_DATA_W = 2 * NODE_FIELD_W + WEIGHT_W;
    localparam int NODE_DATA_W = NODE_FIELD_W + DIST_W;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(16);

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_EDGE_RD,
        ST_NODE_RD,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_LOAD
    } state_t;

    typedef struct packed {
        logic                     improve;
        logic signed [DIST_W-1:0] cand;
    } relax_t;

endpackage

// File: rtl/single_source_shortest_paths.sv
// single-source shortest paths over a stored edge table, one edge relaxed at a time
// clear and add: result word in the output register in the cycle after the input word
// run: root write, n-1 relaxation rounds and a check pass over the edges, n being node_count
//   clamped to [2, NODES] (none when the root is not below n, only the root write on an empty
//   table); each edge: edge ram read, node ram read, relax; each result: node ram read, load
// reset: edge table empty, node_count 16, no result pending; ram contents undefined

module single_source_shortest_paths import ssp_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int EDGES = EDGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel (node_count)
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [COUNT_W-1:0]         cfg_data,
    // input words
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic [NODE_FIELD_W-1:0]    edge_from,
    input  logic [NODE_FIELD_W-1:0]    edge_to,
    input  logic signed [WEIGHT_W-1:0] edge_weight,
    input  logic [NODE_FIELD_W-1:0]    root,
    // result words
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [NODE_FIELD_W-1:0]    node,
    output logic signed [DIST_W-1:0]   distance,
    output logic [NODE_FIELD_W-1:0]    predecessor,
    output logic                       reachable,
    output logic                       negative_cycle,
    output logic                       status,
    output logic                       last
);

    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int NADDR_W = $clog2(NODES);
    localparam int EADDR_W = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECNT_W  = $clog2(EDGES + 1);
    localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // control state
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   node_count_reg, node_count_next;
    logic [ECNT_W-1:0]    edge_total_reg, edge_total_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     round_reg, round_next;
    logic [ECNT_W-1:0]    e_reg, e_next;
    logic [NADDR_W-1:0]   i_reg, i_next;
    logic [NODE_FIELD_W-1:0] root_reg, root_next;
    logic                 check_reg, check_next;
    logic                 neg_reg, neg_next;
    logic [NODES-1:0]     reached_reg, reached_next;
    logic                 out_valid_reg, out_valid_next;

    // result word register
    logic                     out_load;
    logic [NODE_FIELD_W-1:0]  node_reg, node_next;
    logic signed [DIST_W-1:0] distance_reg, distance_next;
    logic [NODE_FIELD_W-1:0]  pred_reg, pred_next;
    logic                     reach_reg, reach_next;
    logic                     negc_reg, negc_next;
    logic                     status_reg, status_next;
    logic                     last_reg, last_next;

    // ram ports
    logic                     edge_we, edge_re;
    logic [EADDR_W-1:0]       edge_waddr, edge_raddr;
    logic [EDGE_DATA_W-1:0]   edge_wdata, edge_rdata;
    logic                     node_we, node_re;
    logic [NADDR_W-1:0]       node_waddr, src_raddr, dst_raddr;
    logic [NODE_DATA_W-1:0]   node_wdata, src_rdata, dst_rdata;

    // decoded edge and node words
    logic [NODE_FIELD_W-1:0]  e_src, e_dst;
    logic signed [WEIGHT_W-1:0] e_weight;
    logic [NADDR_W-1:0]       e_src_addr, e_dst_addr;
    logic signed [DIST_W-1:0] dist_src, dist_dst;
    logic [NODE_FIELD_W-1:0]  parent_out;
    relax_t                   relax;

    logic                     out_free;
    logic                     in_accept;
    logic                     table_full;
    logic [CMP_W-1:0]         count_ext;
    logic [CMP_W-1:0]         n_clamped;
    logic                     edge_pass_end;
    logic                     last_node;

    assign cfg_ready = 1'b1;

    // output register frees up when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    assign table_full = (edge_total_reg == ECNT_W'(EDGES));

    // node_count clamped to the supported range at run start
    assign count_ext = CMP_W'(node_count_reg);
    always_comb
    begin
        if (count_ext < CMP_W'(2))
        begin
            n_clamped = CMP_W'(2);
        end
        else if (count_ext > CMP_W'(NODES))
        begin
            n_clamped = CMP_W'(NODES);
        end
        else
        begin
            n_clamped = count_ext;
        end
    end

    // edge word: {from, to, weight}
    assign e_src    = edge_rdata[EDGE_DATA_W-1 -: NODE_FIELD_W];
    assign e_dst    = edge_rdata[WEIGHT_W +: NODE_FIELD_W];
    assign e_weight = edge_rdata[WEIGHT_W-1:0];

    // node addresses; out-of-range endpoints are rejected by the relax unit
    assign e_src_addr = NADDR_W'(e_src);
    assign e_dst_addr = NADDR_W'(e_dst);

    // node word: {parent, distance}
    assign dist_src   = src_rdata[DIST_W-1:0];
    assign dist_dst   = dst_rdata[DIST_W-1:0];
    assign parent_out = src_rdata[NODE_DATA_W-1 -: NODE_FIELD_W];

    assign edge_pass_end = (e_reg + ECNT_W'(1)) == edge_total_reg;
    assign last_node     = CMP_W'(i_reg) == (CMP_W'(n_reg) - CMP_W'(1));

    ssp_relax #(
        .NODES (NODES)
    ) u_relax (
        .src         (e_src),
        .dst         (e_dst),
        .weight      (e_weight),
        .node_total  (n_reg),
        .src_reached (reached_reg[src_raddr]),
        .dst_reached (reached_reg[dst_raddr]),
        .dist_src    (dist_src),
        .dist_dst    (dist_dst),
        .result      (relax)
    );

    // edge table
    ssp_ram #(
        .WIDTH (EDGE_DATA_W),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // node table, kept in two identical copies so source and target read together
    ssp_ram #(
        .WIDTH (NODE_DATA_W),
        .DEPTH (NODES)
    ) u_src_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    ssp_ram #(
        .WIDTH (NODE_DATA_W),
        .DEPTH (NODES)
    ) u_dst_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (dst_raddr),
        .rdata (dst_rdata)
    );

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        edge_total_next = edge_total_reg;
        n_next          = n_reg;
        round_next      = round_reg;
        e_next          = e_reg;
        i_next          = i_reg;
        root_next       = root_reg;
        check_next      = check_reg;
        neg_next        = neg_reg;
        reached_next    = reached_reg;
        out_valid_next  = out_valid_reg && out_stall;

        out_load      = 1'b0;
        node_next     = '0;
        distance_next = '0;
        pred_next     = '0;
        reach_next    = 1'b0;
        negc_next     = 1'b0;
        status_next   = 1'b0;
        last_next     = 1'b1;

        edge_we    = 1'b0;
        edge_waddr = edge_total_reg[EADDR_W-1:0];
        edge_wdata = {edge_from, edge_to, edge_weight};
        edge_re    = 1'b0;
        edge_raddr = e_reg[EADDR_W-1:0];

        node_we    = 1'b0;
        node_waddr = e_dst_addr;
        node_wdata = {e_src, relax.cand};
        node_re    = 1'b0;
        src_raddr  = e_src_addr;
        dst_raddr  = e_dst_addr;

        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (operation)
                        OP_CLEAR:
                        begin
                            edge_total_next = '0;
                            out_load        = 1'b1;
                            out_valid_next  = 1'b1;
                        end
                        OP_ADD:
                        begin
                            if (!table_full)
                            begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + ECNT_W'(1);
                            end
                            status_next    = table_full;
                            out_load       = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        OP_RUN:
                        begin
                            n_next       = n_clamped[CNT_W-1:0];
                            reached_next = '0;
                            neg_next     = 1'b0;
                            check_next   = 1'b0;
                            round_next   = CNT_W'(1);
                            e_next       = '0;
                            i_next       = '0;
                            root_next    = root;
                            if (CMP_W'(root) < n_clamped)
                            begin
                                reached_next[NADDR_W'(root)] = 1'b1;
                                state_next = ST_ROOT;
                            end
                            else
                            begin
                                state_next = ST_OUT_RD;
                            end
                        end
                        default:
                        begin
                            // unused code, no result
                        end
                    endcase
                end
            end
            ST_ROOT:
            begin
                // root starts at distance 0 and is its own parent
                node_we    = 1'b1;
                node_waddr = NADDR_W'(root_reg);
                node_wdata = {root_reg, {DIST_W{1'b0}}};
                state_next = (edge_total_reg == '0) ? ST_OUT_RD : ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                edge_re    = 1'b1;
                state_next = ST_NODE_RD;
            end
            ST_NODE_RD:
            begin
                node_re    = 1'b1;
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (relax.improve)
                begin
                    if (check_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        node_we                  = 1'b1;
                        reached_next[dst_raddr]  = 1'b1;
                    end
                end
                if (edge_pass_end)
                begin
                    e_next = '0;
                    if (check_reg)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        if (round_reg == (n_reg - CNT_W'(1)))
                        begin
                            check_next = 1'b1;
                        end
                        else
                        begin
                            round_next = round_reg + CNT_W'(1);
                        end
                        state_next = ST_EDGE_RD;
                    end
                end
                else
                begin
                    e_next     = e_reg + ECNT_W'(1);
                    state_next = ST_EDGE_RD;
                end
            end
            ST_OUT_RD:
            begin
                node_re    = 1'b1;
                src_raddr  = i_reg;
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                // node ram data holds until the output register has room
                src_raddr = i_reg;
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    node_next      = NODE_FIELD_W'(CMP_W'(i_reg));
                    reach_next     = reached_reg[i_reg];
                    distance_next  = reached_reg[i_reg] ? dist_src : '0;
                    pred_next      = reached_reg[i_reg] ? parent_out : '0;
                    negc_next      = neg_reg;
                    last_next      = last_node;
                    if (last_node)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + NADDR_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            edge_total_reg <= '0;
            n_reg          <= CNT_W'(2);
            round_reg      <= '0;
            e_reg          <= '0;
            i_reg          <= '0;
            root_reg       <= '0;
            check_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            reached_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_total_reg <= edge_total_next;
            n_reg          <= n_next;
            round_reg      <= round_next;
            e_reg          <= e_next;
            i_reg          <= i_next;
            root_reg       <= root_next;
            check_reg      <= check_next;
            neg_reg        <= neg_next;
            reached_reg    <= reached_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result word payload, loaded only when the register takes a new word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            node_reg     <= node_next;
            distance_reg <= distance_next;
            pred_reg     <= pred_next;
            reach_reg    <= reach_next;
            negc_reg     <= negc_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign node           = node_reg;
    assign distance       = distance_reg;
    assign predecessor    = pred_reg;
    assign reachable      = reach_reg;
    assign negative_cycle = negc_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

// File: rtl/ssp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ssp_relax.sv
// edge relaxation test: saturating candidate distance and improvement check
// depends on ssp_pkg

module ssp_relax import ssp_pkg::*; #(
    parameter int NODES = NODES_DEF,
    localparam int CNT_W = $clog2(NODES + 1)
) (
    input  logic [NODE_FIELD_W-1:0]  src,
    input  logic [NODE_FIELD_W-1:0]  dst,
    input  logic signed [WEIGHT_W-1:0] weight,
    input  logic [CNT_W-1:0]         node_total,
    input  logic                     src_reached,
    input  logic                     dst_reached,
    input  logic signed [DIST_W-1:0] dist_src,
    input  logic signed [DIST_W-1:0] dist_dst,
    output relax_t                   result
);

    localparam int CMP_W = (CNT_W > NODE_FIELD_W + 1) ? CNT_W : NODE_FIELD_W + 1;

    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] cand;
    logic                     in_range;

    // one extra bit catches overflow of the 24-bit distance
    assign sum = {dist_src[DIST_W-1], dist_src}
               + {{(DIST_W + 1 - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};

    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end

    assign in_range = (CMP_W'(src) < CMP_W'(node_total))
                   && (CMP_W'(dst) < CMP_W'(node_total));

    assign result.cand    = cand;
    assign result.improve = in_range && src_reached
                         && (!dst_reached || (cand < dist_dst));

endmodule

// File: verif/single_source_shortest_paths_tb.sv
// self-checking testbench for single_source_shortest_paths: edge table loads, clears and runs
// depends on rtl/ssp_pkg.sv and rtl/single_source_shortest_paths.sv

module single_source_shortest_paths_tb;
    import ssp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_SLOTS   = EDGES_DEF;
    localparam int NODE_SLOTS   = NODES_DEF;
    localparam int RANDOM_WORDS = 225;
    localparam int QUIET_WORDS  = 35;       // trailing words with no idling on either side
    localparam int IDLE_MARGIN  = 12;       // cycles after the last result before a register write
    localparam int CYCLE_LIMIT  = 10000000;
    localparam int BY_MODEL     = -1;       // step checked against the predictor

    // operation code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic {STEP_WORD, STEP_CFG} step_kind_t;

    // one result word as seen on the output port
    typedef struct {
        logic [NODE_FIELD_W-1:0]  node;
        logic signed [DIST_W-1:0] distance;
        logic [NODE_FIELD_W-1:0]  predecessor;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     status;
        logic                     last;
    } node_report_t;

    // one row of the directed stimulus
    typedef struct {
        step_kind_t                  kind;
        logic [OP_W-1:0]             op;
        logic [NODE_FIELD_W-1:0]     src;
        logic [NODE_FIELD_W-1:0]     dst;
        logic signed [WEIGHT_W-1:0]  weight;
        logic [NODE_FIELD_W-1:0]     start;
        logic [COUNT_W-1:0]          count;
        int                          typed_count;
        logic                        typed_status;
    } step_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [COUNT_W-1:0]         cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [OP_W-1:0]            operation = OP_CLEAR;
    logic [NODE_FIELD_W-1:0]    edge_from = '0;
    logic [NODE_FIELD_W-1:0]    edge_to = '0;
    logic signed [WEIGHT_W-1:0] edge_weight = '0;
    logic [NODE_FIELD_W-1:0]    root = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [NODE_FIELD_W-1:0]    node;
    logic signed [DIST_W-1:0]   distance;
    logic [NODE_FIELD_W-1:0]    predecessor;
    logic                       reachable;
    logic                       negative_cycle;
    logic                       status;
    logic                       last;

    // predictor state: stored edges, node count register, per-run node labels
    logic [NODE_FIELD_W-1:0]    edge_src [EDGE_SLOTS];
    logic [NODE_FIELD_W-1:0]    edge_dst [EDGE_SLOTS];
    int                         edge_wt  [EDGE_SLOTS];
    int                         edges_held = 0;
    logic [COUNT_W-1:0]         node_limit = NODE_COUNT_RST;
    int                         node_dist [NODE_SLOTS];
    bit                         node_seen [NODE_SLOTS];
    logic [NODE_FIELD_W-1:0]    node_parent [NODE_SLOTS];

    node_report_t reports_due[$];
    step_t        directed_steps[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  runs_sent = 0;
    int  drops_sent = 0;
    int  cycle_runs = 0;
    int  reports_checked = 0;
    int  count_writes = 0;
    int  gap_odds = 0;
    int  stall_odds = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    single_source_shortest_paths dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .edge_from      (edge_from),
        .edge_to        (edge_to),
        .edge_weight    (edge_weight),
        .root           (root),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node           (node),
        .distance       (distance),
        .predecessor    (predecessor),
        .reachable      (reachable),
        .negative_cycle (negative_cycle),
        .status         (status),
        .last           (last)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, reports_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // node count in effect, clamped like the block does
    function automatic int active_nodes();
        if (node_limit < 2)
            return 2;
        if (node_limit > NODE_SLOTS)
            return NODE_SLOTS;
        return int'(node_limit);
    endfunction

    // would edge e lower its target's label; commit applies the change
    function automatic bit edge_improves(int e, int n, bit commit);
        int     u;
        int     v;
        longint sum;
        int     cand;
        u = int'(edge_src[e]);
        v = int'(edge_dst[e]);
        if (u >= n || v >= n || !node_seen[u])
            return 1'b0;
        sum = longint'(node_dist[u]) + longint'(edge_wt[e]);
        if (sum > DIST_MAX)
            cand = DIST_MAX;
        else if (sum < DIST_MIN)
            cand = DIST_MIN;
        else
            cand = int'(sum);
        if (node_seen[v] && cand >= node_dist[v])
            return 1'b0;
        if (commit)
        begin
            node_dist[v]   = cand;
            node_seen[v]   = 1'b1;
            node_parent[v] = edge_src[e];
        end
        return 1'b1;
    endfunction

    // apply one accepted input word to the predictor and queue its result words
    task automatic predict_reports(input logic [OP_W-1:0] op,
                                   input logic [NODE_FIELD_W-1:0] src,
                                   input logic [NODE_FIELD_W-1:0] dst,
                                   input logic signed [WEIGHT_W-1:0] w,
                                   input logic [NODE_FIELD_W-1:0] start);
        node_report_t r;
        int           n;
        bit           neg;
        r = '{default: 0};
        case (op)
            OP_CLEAR:
            begin
                edges_held = 0;
                r.last = 1'b1;
                reports_due.push_back(r);
            end
            OP_ADD:
            begin
                if (edges_held >= EDGE_SLOTS)
                begin
                    r.status = 1'b1;
                    drops_sent++;
                end
                else
                begin
                    edge_src[edges_held] = src;
                    edge_dst[edges_held] = dst;
                    edge_wt[edges_held]  = int'(w);
                    edges_held++;
                end
                r.last = 1'b1;
                reports_due.push_back(r);
            end
            OP_RUN:
            begin
                n = active_nodes();
                neg = 1'b0;
                for (int i = 0; i < NODE_SLOTS; i++)
                begin
                    node_dist[i]   = 0;
                    node_seen[i]   = 1'b0;
                    node_parent[i] = '0;
                end
                if (start < n)
                begin
                    node_seen[start]   = 1'b1;
                    node_parent[start] = start;
                    for (int pass = 0; pass + 1 < n; pass++)
                        for (int e = 0; e < edges_held; e++)
                            void'(edge_improves(e, n, 1'b1));
                    // any edge still able to relax means a reachable negative cycle
                    for (int e = 0; e < edges_held; e++)
                        if (edge_improves(e, n, 1'b0))
                            neg = 1'b1;
                end
                if (neg)
                    cycle_runs++;
                for (int i = 0; i < n; i++)
                begin
                    r.node           = i[NODE_FIELD_W-1:0];
                    r.reachable      = node_seen[i];
                    r.distance       = node_seen[i] ? node_dist[i][DIST_W-1:0] : '0;
                    r.predecessor    = node_seen[i] ? node_parent[i] : '0;
                    r.negative_cycle = neg;
                    r.status         = 1'b0;
                    r.last           = (i == n - 1);
                    reports_due.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // drive one input word and hold it until accepted; typed_count overrides the predictor
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic [NODE_FIELD_W-1:0] src,
                             input logic [NODE_FIELD_W-1:0] dst,
                             input logic signed [WEIGHT_W-1:0] w,
                             input logic [NODE_FIELD_W-1:0] start,
                             input int typed_count,
                             input logic typed_status);
        int           queued;
        node_report_t r;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        operation   <= op;
        edge_from   <= src;
        edge_to     <= dst;
        edge_weight <= w;
        root        <= start;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        queued = reports_due.size();
        predict_reports(op, src, dst, w, start);
        if (typed_count != BY_MODEL)
        begin
            while (reports_due.size() > queued)
                void'(reports_due.pop_back());
            if (typed_count == 1)
            begin
                r = '{default: 0};
                r.status = typed_status;
                r.last = 1'b1;
                reports_due.push_back(r);
            end
        end
        if (op != OP_UNUSED)
            words_sent++;
        if (op == OP_RUN)
            runs_sent++;
    endtask

    // register write, only once the block has gone idle
    task automatic set_node_count(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_MARGIN) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        node_limit = value;
        count_writes++;
    endtask

    task automatic plan(input step_kind_t kind, input logic [OP_W-1:0] op,
                        input int src, input int dst, input int w, input int start,
                        input int count, input int typed_count, input logic typed_status);
        step_t s;
        s.kind         = kind;
        s.op           = op;
        s.src          = src[NODE_FIELD_W-1:0];
        s.dst          = dst[NODE_FIELD_W-1:0];
        s.weight       = w[WEIGHT_W-1:0];
        s.start        = start[NODE_FIELD_W-1:0];
        s.count        = count[COUNT_W-1:0];
        s.typed_count  = typed_count;
        s.typed_status = typed_status;
        directed_steps.push_back(s);
    endtask

    // mostly nodes in use, sometimes any node
    function automatic logic [NODE_FIELD_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 85)
            return NODE_FIELD_W'($urandom_range(0, active_nodes() - 1));
        return NODE_FIELD_W'($urandom_range(0, NODE_SLOTS - 1));
    endfunction

    // weights lean positive so runs mostly converge; extremes and noise mixed in
    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return WEIGHT_W'($urandom_range(0, 200));
            6:                return -WEIGHT_W'($urandom_range(1, 50));
            7, 8:             return WEIGHT_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return -16'sd1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        if ($urandom_range(0, 3) != 0)
            return COUNT_W'($urandom_range(2, NODE_SLOTS));
        case ($urandom_range(0, 4))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd17;
            3:       return 5'd31;
            default: return COUNT_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stall bursts, intensity re-picked now and then
    always @(posedge clk)
    begin
        if ($urandom_range(0, 255) == 0)
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        if (quiet || stall_odds == 0)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(1, stall_odds) == 1)
        begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare every accepted result word with the oldest one predicted
    always @(posedge clk)
    begin
        node_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                $error("result word for node %0d with nothing predicted", node);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("node", want.node, node);
                check_field("distance", want.distance, distance);
                check_field("predecessor", want.predecessor, predecessor);
                check_field("reachable", want.reachable, reachable);
                check_field("negative_cycle", want.negative_cycle, negative_cycle);
                check_field("status", want.status, status);
                check_field("last", want.last, last);
                reports_checked++;
            end
        end
    end

    initial
    begin
        int n_seq;
        int directed_words;
        int adds;

        // directed part: rows with a one-word answer carry it typed in (count, status)
        plan(STEP_WORD, OP_CLEAR, 0, 0, 0, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 0, 0, BY_MODEL, 1'b0);         // empty table
        plan(STEP_WORD, OP_ADD, 0, 1, 32767, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_ADD, 1, 2, -32768, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_ADD, 15, 14, 5, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_ADD, 2, 15, -1, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_ADD, 14, 0, 0, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_ADD, 15, 3, 100, 0, 0, 1, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 0, 0, BY_MODEL, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 15, 0, BY_MODEL, 1'b0);
        plan(STEP_WORD, OP_UNUSED, 15, 15, -1, 15, 0, 0, 1'b0);           // ignored, no result
        plan(STEP_WORD, OP_ADD, 3, 3, -7, 0, 0, 1, 1'b0);                 // negative self loop
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 0, 0, BY_MODEL, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 4, 0, BY_MODEL, 1'b0);           // isolated root
        plan(STEP_CFG, OP_CLEAR, 0, 0, 0, 0, 2, 0, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 1, 0, BY_MODEL, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 5, 0, BY_MODEL, 1'b0);           // root outside count
        plan(STEP_CFG, OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0);                 // clamps up to 2
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 0, 0, BY_MODEL, 1'b0);
        plan(STEP_CFG, OP_CLEAR, 0, 0, 0, 0, 31, 0, 1'b0);                // clamps down to 16
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 15, 0, BY_MODEL, 1'b0);
        plan(STEP_CFG, OP_CLEAR, 0, 0, 0, 0, 17, 0, 1'b0);
        plan(STEP_WORD, OP_RUN, 0, 0, 0, 2, 0, BY_MODEL, 1'b0);
        plan(STEP_WORD, OP_CLEAR, 0, 0, 0, 0, 0, 1, 1'b0);
        plan(STEP_CFG, OP_CLEAR, 0, 0, 0, 0, 16, 0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds = 4;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CFG)
                set_node_count(directed_steps[i].count);
            else
                send_word(directed_steps[i].op, directed_steps[i].src, directed_steps[i].dst,
                          directed_steps[i].weight, directed_steps[i].start,
                          directed_steps[i].typed_count, directed_steps[i].typed_status);
        end
        directed_words = words_sent;

        // random part: clear, a handful of edges, then runs; some passes overfill the table
        n_seq = 0;
        while (words_sent - directed_words < RANDOM_WORDS)
        begin
            quiet = (words_sent - directed_words >= RANDOM_WORDS - QUIET_WORDS);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 9;
            endcase
            if (n_seq == 0 || $urandom_range(0, 24) == 0)
            begin
                send_word(OP_CLEAR, pick_node(), pick_node(), pick_weight(), pick_node(),
                          BY_MODEL, 1'b0);
                adds = EDGE_SLOTS + $urandom_range(1, 4);
                repeat (adds)
                    send_word(OP_ADD, pick_node(), pick_node(), pick_weight(), pick_node(),
                              BY_MODEL, 1'b0);
                send_word(OP_RUN, pick_node(), pick_node(), pick_weight(), pick_node(),
                          BY_MODEL, 1'b0);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    set_node_count(pick_count());
                // now and then the table is left to accumulate
                if ($urandom_range(0, 4) != 0)
                    send_word(OP_CLEAR, pick_node(), pick_node(), pick_weight(), pick_node(),
                              BY_MODEL, 1'b0);
                repeat ($urandom_range(0, 10))
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(OP_UNUSED, pick_node(), pick_node(), pick_weight(),
                                  pick_node(), BY_MODEL, 1'b0);
                    send_word(OP_ADD, pick_node(), pick_node(), pick_weight(), pick_node(),
                              BY_MODEL, 1'b0);
                end
                repeat ($urandom_range(1, 2))
                    send_word(OP_RUN, pick_node(), pick_node(), pick_weight(), pick_node(),
                              BY_MODEL, 1'b0);
            end
            n_seq++;
        end
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4 * IDLE_MARGIN) @(posedge clk);
        if (reports_due.size() != 0)
        begin
            $error("%0d predicted result words never arrived", reports_due.size());
            mismatches++;
        end

        $display("covered %0d input words in %0d sequences: %0d runs (%0d with negative cycle)",
                 words_sent, n_seq, runs_sent, cycle_runs);
        $display("%0d adds on a full table, %0d node count writes, %0d result words checked",
                 drops_sent, count_writes, reports_checked);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: single_source_shortest_paths.f
rtl/ssp_pkg.sv
rtl/ssp_ram.sv
rtl/ssp_relax.sv
rtl/single_source_shortest_paths.sv
verif/single_source_shortest_paths_tb.sv
